[design/tpm_pkg.sv]
// Shared types, register indexes and helpers for the tilt mixer.
`timescale 1ns / 1ps
package tpm_pkg;

	localparam int CFG_W = 24;
	localparam int CFG_AW = 3;

	localparam logic [CFG_AW-1:0] REG_GAIN_PROP     = 3'd0;
	localparam logic [CFG_AW-1:0] REG_GAIN_INTEGRAL = 3'd1;
	localparam logic [CFG_AW-1:0] REG_GAIN_DERIV    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_EMA_WEIGHT    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_PLATE_LIMIT   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_BASE_ANGLE    = 3'd5;

	localparam int MUL_W = 64;
	localparam int MUL_BW = 24;
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 10;

	typedef struct packed {
		logic       start;
		logic       accum;
		logic [4:0] nbits;
	} mul_cmd_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7fff;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

[design/tpm_mul.sv]
// Bit-serial shift-add multiplier with optional accumulation.
`timescale 1ns / 1ps
module tpm_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tpm_pkg::mul_cmd_t               cmd,
	input  logic signed [tpm_pkg::MUL_W-1:0] a,
	input  logic [tpm_pkg::MUL_BW-1:0]      b,
	output logic                            busy,
	output logic signed [tpm_pkg::MUL_W-1:0] acc
);
	import tpm_pkg::*;

	logic signed [MUL_W-1:0] a_q;
	logic signed [MUL_W-1:0] acc_q;
	logic [MUL_BW-1:0]       b_q;
	logic [4:0]              cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= cmd.nbits;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// The multiplier word shifts out one bit per cycle, low bit first.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= a;
			b_q <= b;
			if (!cmd.accum) begin
				acc_q <= '0;
			end
		end else if (cnt_q != 5'd0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = (cnt_q != 5'd0);
	assign acc = acc_q;
endmodule

[design/tpm_div.sv]
// Bit-serial restoring divider for unsigned magnitudes.
`timescale 1ns / 1ps
module tpm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tpm_pkg::DIV_NW-1:0] num,
	input  logic [tpm_pkg::DIV_DW-1:0] den,
	output logic                      busy,
	output logic [tpm_pkg::DIV_NW-1:0] quot,
	output logic                      rem_nz
);
	import tpm_pkg::*;

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_DW-1:0] r_q;
	logic [5:0]        cnt_q;
	logic [DIV_DW:0]   r2;
	logic              fits;

	assign r2 = {r_q, n_q[DIV_NW-1]};
	assign fits = (r2 >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(DIV_NW);
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// Quotient bits enter at the bottom as dividend bits leave the top.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (cnt_q != 6'd0) begin
			r_q <= fits ? DIV_DW'(r2 - {1'b0, d_q}) : DIV_DW'(r2);
			n_q <= {n_q[DIV_NW-2:0], fits};
		end
	end

	assign busy = (cnt_q != 6'd0);
	assign quot = n_q;
	assign rem_nz = (r_q != '0);
endmodule

[design/two_axis_pid_tilt_mixer.sv]
// Top level: two-axis filtered PID tilt controller with four-motor mixing.
// Each axis runs ten steps, each an issue state followed by a wait until the unit is idle:
// multiplies of 16, 7, 10, 14, 16, 24, 24 and 24 bits and two 48-bit divides.
// One tick is worked at a time; the input stalls until the result word has left.
// Reset: asynchronous, active low; filter and PID state clear, registers take defaults.
`timescale 1ns / 1ps
module two_axis_pid_tilt_mixer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tpm_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [tpm_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        ball_found,
	input  logic signed [15:0]          ball_x,
	input  logic signed [15:0]          ball_y,
	input  logic signed [15:0]          aim_x,
	input  logic signed [15:0]          aim_y,
	input  logic [15:0]                 elapsed_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [15:0]          angle_right_back,
	output logic signed [15:0]          angle_right_front,
	output logic signed [15:0]          angle_left_front,
	output logic signed [15:0]          angle_left_back
);
	import tpm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	typedef enum logic [9:0] {
		ST_EMA  = 10'b0000000001,
		ST_IMUL = 10'b0000000010,
		ST_IDIV = 10'b0000000100,
		ST_RMUL = 10'b0000001000,
		ST_RDIV = 10'b0000010000,
		ST_SM1  = 10'b0000100000,
		ST_SM2  = 10'b0001000000,
		ST_P    = 10'b0010000000,
		ST_I    = 10'b0100000000,
		ST_D    = 10'b1000000000
	} step_t;

	localparam logic signed [49:0] INTEG_LIMIT = 50'sd3276800;

	state_t state_q;
	step_t  step_q;
	logic   sel_q;

	logic [23:0] gain_prop_q, gain_integral_q, gain_deriv_q;
	logic [15:0] ema_weight_q;
	logic [14:0] plate_limit_q, base_angle_q;

	logic signed [28:0] raw_x_q, raw_y_q, aim_x_q, aim_y_q;
	logic [6:0]         ms_q;
	logic signed [31:0] filt_x_q, filt_y_q, integ_x_q, integ_y_q;
	logic signed [31:0] prev_x_q, prev_y_q, smooth_x_q, smooth_y_q;
	logic signed [33:0] err_q;
	logic signed [49:0] rate_q;
	logic               neg_q;
	logic signed [10:0] tilt_x_q;
	logic signed [15:0] rb_q, rf_q, lf_q, lb_q;

	mul_cmd_t                mul_cmd;
	logic signed [MUL_W-1:0] mul_a, mul_acc;
	logic [MUL_BW-1:0]       mul_b;
	logic                    mul_busy;
	logic                    div_start, div_busy, div_rem_nz;
	logic [DIV_NW-1:0]       div_num, div_quot;
	logic [DIV_DW-1:0]       div_den;

	logic signed [28:0] cur_raw, cur_aim;
	logic signed [31:0] cur_f, cur_integ, cur_prev, cur_smooth;
	logic signed [31:0] f_new;
	logic signed [33:0] err_new;
	logic signed [MUL_W-1:0] nsum;
	logic signed [49:0] qext, ig_sum;
	logic signed [31:0] ig_new;
	logic signed [MUL_W-1:0] sm_full, tilt_full;
	logic signed [31:0] sm_new;
	logic signed [10:0] tilt_new;
	logic signed [16:0] abs_bx, abs_by;
	logic               pos_ok;
	logic signed [17:0] m_base, m_roll;

	assign cur_raw    = sel_q ? raw_y_q : raw_x_q;
	assign cur_aim    = sel_q ? aim_y_q : aim_x_q;
	assign cur_f      = sel_q ? filt_y_q : filt_x_q;
	assign cur_integ  = sel_q ? integ_y_q : integ_x_q;
	assign cur_prev   = sel_q ? prev_y_q : prev_x_q;
	assign cur_smooth = sel_q ? smooth_y_q : smooth_x_q;

	assign f_new = cur_f + 32'((mul_acc + 64'sd32768) >>> 16);
	assign err_new = 34'(f_new) - 34'(cur_aim);
	assign nsum = mul_acc + 64'sd500;
	assign qext = $signed({2'b00, div_quot});
	// Floor division: a negative dividend with a remainder rounds one further down.
	assign ig_sum = 50'(cur_integ) + (neg_q ? (-qext - 50'(div_rem_nz)) : qext);
	always_comb begin
		if (ig_sum > INTEG_LIMIT) begin
			ig_new = 32'(INTEG_LIMIT);
		end else if (ig_sum < -INTEG_LIMIT) begin
			ig_new = 32'(-INTEG_LIMIT);
		end else begin
			ig_new = 32'(ig_sum);
		end
	end

	assign sm_full = (mul_acc + 64'sd32768) >>> 16;
	always_comb begin
		if (sm_full > 64'sd2147483647) begin
			sm_new = 32'sh7fffffff;
		end else if (sm_full < -64'sd2147483648) begin
			sm_new = 32'sh80000000;
		end else begin
			sm_new = 32'(sm_full);
		end
	end

	assign tilt_full = (mul_acc + 64'sd33554432) >>> 26;
	always_comb begin
		if (tilt_full > 64'sd960) begin
			tilt_new = 11'sd960;
		end else if (tilt_full < -64'sd640) begin
			tilt_new = -11'sd640;
		end else begin
			tilt_new = 11'(tilt_full);
		end
	end

	always_comb begin
		mul_cmd = '0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		if (state_q == S_ISSUE) begin
			unique case (step_q)
				ST_EMA: begin
					mul_cmd = '{start: 1'b1, accum: 1'b0, nbits: 5'd16};
					mul_a = 64'(34'(cur_raw) - 34'(cur_f));
					mul_b = 24'(ema_weight_q);
				end
				ST_IMUL: begin
					mul_cmd = '{start: 1'b1, accum: 1'b0, nbits: 5'd7};
					mul_a = 64'(err_q);
					mul_b = 24'(ms_q);
				end
				ST_IDIV: begin
					div_start = 1'b1;
					div_num = DIV_NW'(nsum[MUL_W-1] ? -nsum : nsum);
					div_den = 10'd1000;
				end
				ST_RMUL: begin
					mul_cmd = '{start: 1'b1, accum: 1'b0, nbits: 5'd10};
					mul_a = 64'(35'(err_q) - 35'(cur_prev));
					mul_b = 24'd1000;
				end
				ST_RDIV: begin
					div_start = 1'b1;
					div_num = DIV_NW'(mul_acc[MUL_W-1] ? -mul_acc : mul_acc);
					div_den = 10'(ms_q);
				end
				ST_SM1: begin
					mul_cmd = '{start: 1'b1, accum: 1'b0, nbits: 5'd14};
					mul_a = 64'(rate_q);
					mul_b = 24'd13107;
				end
				ST_SM2: begin
					mul_cmd = '{start: 1'b1, accum: 1'b1, nbits: 5'd16};
					mul_a = 64'(cur_smooth);
					mul_b = 24'd52429;
				end
				ST_P: begin
					mul_cmd = '{start: 1'b1, accum: 1'b0, nbits: 5'd24};
					mul_a = 64'(err_q);
					mul_b = gain_prop_q;
				end
				ST_I: begin
					mul_cmd = '{start: 1'b1, accum: 1'b1, nbits: 5'd24};
					mul_a = 64'(cur_integ);
					mul_b = gain_integral_q;
				end
				ST_D: begin
					mul_cmd = '{start: 1'b1, accum: 1'b1, nbits: 5'd24};
					mul_a = 64'(cur_smooth);
					mul_b = gain_deriv_q;
				end
				default: begin
				end
			endcase
		end
	end

	tpm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.acc    (mul_acc)
	);

	tpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot),
		.rem_nz (div_rem_nz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q     <= 24'd9765;
			gain_integral_q <= 24'd7340;
			gain_deriv_q    <= 24'd4456;
			ema_weight_q    <= 16'd9830;
			plate_limit_q   <= 15'd2880;
			base_angle_q    <= 15'd8640;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GAIN_PROP:     gain_prop_q <= cfg_data;
				REG_GAIN_INTEGRAL: gain_integral_q <= cfg_data;
				REG_GAIN_DERIV:    gain_deriv_q <= cfg_data;
				REG_EMA_WEIGHT:    ema_weight_q <= cfg_data[15:0];
				REG_PLATE_LIMIT:   plate_limit_q <= cfg_data[14:0];
				REG_BASE_ANGLE:    base_angle_q <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	assign abs_bx = ball_x[15] ? -17'(ball_x) : 17'(ball_x);
	assign abs_by = ball_y[15] ? -17'(ball_y) : 17'(ball_y);
	assign pos_ok = ball_found && (abs_bx <= $signed({2'b00, plate_limit_q}))
		&& (abs_by <= $signed({2'b00, plate_limit_q}));

	assign m_base  = $signed({3'b000, base_angle_q});
	assign m_roll  = -18'(tilt_x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= ST_EMA;
			sel_q      <= 1'b0;
			filt_x_q   <= '0;
			filt_y_q   <= '0;
			integ_x_q  <= '0;
			integ_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			smooth_x_q <= '0;
			smooth_y_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ISSUE;
						step_q  <= ST_EMA;
						sel_q   <= 1'b0;
					end
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!mul_busy && !div_busy) begin
						state_q <= S_ISSUE;
						unique case (step_q)
							ST_EMA: begin
								if (sel_q) filt_y_q <= f_new;
								else filt_x_q <= f_new;
								step_q <= ST_IMUL;
							end
							ST_IMUL: step_q <= ST_IDIV;
							ST_IDIV: begin
								if (sel_q) integ_y_q <= ig_new;
								else integ_x_q <= ig_new;
								step_q <= ST_RMUL;
							end
							ST_RMUL: step_q <= ST_RDIV;
							ST_RDIV: begin
								if (sel_q) prev_y_q <= 32'(err_q);
								else prev_x_q <= 32'(err_q);
								step_q <= ST_SM1;
							end
							ST_SM1: step_q <= ST_SM2;
							ST_SM2: begin
								if (sel_q) smooth_y_q <= sm_new;
								else smooth_x_q <= sm_new;
								step_q <= ST_P;
							end
							ST_P: step_q <= ST_I;
							ST_I: step_q <= ST_D;
							ST_D: begin
								step_q <= ST_EMA;
								if (sel_q) begin
									state_q <= S_OUT;
								end else begin
									sel_q <= 1'b1;
								end
							end
							default: step_q <= ST_EMA;
						endcase
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers carry no reset; every tick writes them before use.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			raw_x_q <= pos_ok ? 29'($signed({ball_x, 12'd0})) : '0;
			raw_y_q <= pos_ok ? 29'($signed({ball_y, 12'd0})) : '0;
			aim_x_q <= 29'($signed({aim_x, 12'd0}));
			aim_y_q <= 29'($signed({aim_y, 12'd0}));
			ms_q    <= (elapsed_ms == 16'd0 || elapsed_ms > 16'd100) ? 7'd10
				: elapsed_ms[6:0];
		end
		if (state_q == S_ISSUE) begin
			if (step_q == ST_IDIV) neg_q <= nsum[MUL_W-1];
			if (step_q == ST_RDIV) neg_q <= mul_acc[MUL_W-1];
		end
		if (state_q == S_WAIT && !mul_busy && !div_busy) begin
			if (step_q == ST_EMA) err_q <= err_new;
			if (step_q == ST_RDIV) rate_q <= neg_q ? -qext : qext;
			if (step_q == ST_D && !sel_q) tilt_x_q <= tilt_new;
		end
		// Pitch is taken straight from the multiplier in the last step of the y axis.
		if (state_q == S_WAIT && step_q == ST_D && sel_q && !mul_busy) begin
			rb_q <= sat16(m_base - 18'(tilt_new) + m_roll);
			rf_q <= sat16(m_base + 18'(tilt_new) + m_roll);
			lf_q <= sat16(m_base + 18'(tilt_new) - m_roll);
			lb_q <= sat16(m_base - 18'(tilt_new) - m_roll);
		end
	end

	assign in_stall          = (state_q != S_IDLE);
	assign out_valid         = (state_q == S_OUT);
	assign angle_right_back  = rb_q;
	assign angle_right_front = rf_q;
	assign angle_left_front  = lf_q;
	assign angle_left_back   = lb_q;
endmodule

[design/tpm_checker.sv]
// Port-level checks of the tilt mixer, bound to the top level.
`timescale 1ns / 1ps
module tpm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] angle_right_back,
	input logic signed [15:0] angle_left_back
);
	// An accepted word closes the input until its result is delivered.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after an accepted word");

	// No new word is taken while a result waits.
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is pending");

	// A delivered result is not shown twice.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result word repeated");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(angle_right_back)
		&& $stable(angle_left_back))
		else $error("stalled result changed");
endmodule

bind two_axis_pid_tilt_mixer tpm_checker u_tpm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.angle_right_back (angle_right_back),
	.angle_left_back  (angle_left_back)
);

[tb/two_axis_pid_tilt_mixer_test.sv]
// Self-checking testbench for the two-axis PID tilt mixer.
`timescale 1ns / 1ps
module two_axis_pid_tilt_mixer_test;
	import tpm_pkg::*;

	localparam logic [CFG_AW-1:0] REG_NONE = 3'd7;

	typedef struct {
		logic signed [15:0] rb, rf, lf, lb;
	} angles_t;

	class tilt_board;
		bit [23:0] kp, ki, kd;
		bit [15:0] wt;
		bit [14:0] lim, base;
		longint fx, fy, ix, iy, px, py, sx, sy;
		angles_t pending[$];
		int errors;

		function void reset_state();
			kp = 24'd9765; ki = 24'd7340; kd = 24'd4456; wt = 16'd9830;
			lim = 15'd2880; base = 15'd8640;
			fx = 0; fy = 0; ix = 0; iy = 0; px = 0; py = 0; sx = 0; sy = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_AW-1:0] a, logic [CFG_W-1:0] d);
			case (a)
				REG_GAIN_PROP: kp = d;
				REG_GAIN_INTEGRAL: ki = d;
				REG_GAIN_DERIV: kd = d;
				REG_EMA_WEIGHT: wt = d[15:0];
				REG_PLATE_LIMIT: lim = d[14:0];
				REG_BASE_ANGLE: base = d[14:0];
				default: ;
			endcase
		endfunction

		// Adds half before the arithmetic shift, so the result rounds to nearest, ties upward.
		function longint rshr(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint fdiv(longint n, longint d);
			longint q;
			q = n / d;
			if (n % d != 0 && n < 0) q--;
			return q;
		endfunction

		function longint run_axis(longint raw, longint aim, longint ms,
				inout longint f, inout longint ig, inout longint pv, inout longint sm);
			longint e, r;
			f = f + rshr((raw - f) * longint'(wt), 16);
			f = longint'(int'(f));
			e = f - aim;
			ig = clip(ig + fdiv(e * ms + 500, 1000), -3276800, 3276800);
			r = ((e - pv) * 1000) / ms;
			sm = clip(rshr(r * 13107 + sm * 52429, 16), -64'sd2147483648, 64'sd2147483647);
			pv = longint'(int'(e));
			return clip(rshr(longint'(kp) * e + longint'(ki) * ig + longint'(kd) * sm, 26),
				-640, 960);
		endfunction

		function void note_tick(bit found, logic signed [15:0] bx, logic signed [15:0] by,
				logic signed [15:0] ax, logic signed [15:0] ay, logic [15:0] el);
			longint rx, ry, ms, roll, pitch, b, abx, aby;
			angles_t a;
			rx = 0; ry = 0;
			abx = bx < 0 ? -longint'(bx) : longint'(bx);
			aby = by < 0 ? -longint'(by) : longint'(by);
			if (found && abx <= longint'(lim) && aby <= longint'(lim)) begin
				rx = longint'(bx) * 4096;
				ry = longint'(by) * 4096;
			end
			ms = longint'(el);
			if (ms == 0 || ms > 100) ms = 10;
			roll = -run_axis(rx, longint'(ax) * 4096, ms, fx, ix, px, sx);
			pitch = run_axis(ry, longint'(ay) * 4096, ms, fy, iy, py, sy);
			b = longint'(base);
			a.rb = 16'(clip(b - pitch + roll, -32768, 32767));
			a.rf = 16'(clip(b + pitch + roll, -32768, 32767));
			a.lf = 16'(clip(b + pitch - roll, -32768, 32767));
			a.lb = 16'(clip(b - pitch - roll, -32768, 32767));
			pending.push_back(a);
		endfunction

		function void check_word(angles_t got);
			angles_t w;
			if (pending.size() == 0) begin
				$error("unexpected result word");
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.rb !== w.rb) begin
				$error("angle_right_back exp %0d got %0d", w.rb, got.rb); errors++;
			end
			if (got.rf !== w.rf) begin
				$error("angle_right_front exp %0d got %0d", w.rf, got.rf); errors++;
			end
			if (got.lf !== w.lf) begin
				$error("angle_left_front exp %0d got %0d", w.lf, got.lf); errors++;
			end
			if (got.lb !== w.lb) begin
				$error("angle_left_back exp %0d got %0d", w.lb, got.lb); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic ball_found = 0;
	logic signed [15:0] ball_x = 0, ball_y = 0, aim_x = 0, aim_y = 0;
	logic [15:0] elapsed_ms = 0;
	logic signed [15:0] angle_right_back, angle_right_front, angle_left_front, angle_left_back;

	tilt_board sb = new();
	int idle_cycles = 0;
	bit stim_done = 0;

	two_axis_pid_tilt_mixer u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: stall pattern of its own, sometimes long stalls, sometimes none.
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 900)) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		angles_t g;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				g.rb = angle_right_back; g.rf = angle_right_front;
				g.lf = angle_left_front; g.lb = angle_left_back;
				sb.check_word(g);
			end
			if (idle_cycles > 20000) begin
				$display("two_axis_pid_tilt_mixer_test: FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_AW-1:0] a, logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1; cfg_addr <= a; cfg_data <= d;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_reg(a, d);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	// Presents one word; returns at the falling edge after acceptance.
	task automatic send_tick(bit f, logic signed [15:0] bx, logic signed [15:0] by,
			logic signed [15:0] ax, logic signed [15:0] ay, logic [15:0] el);
		@(negedge clk);
		in_valid <= 1; ball_found <= f; ball_x <= bx; ball_y <= by;
		aim_x <= ax; aim_y <= ay; elapsed_ms <= el;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_tick(f, bx, by, ax, ay, el);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic random_tick(int lim);
		logic signed [15:0] bx, by, ax, ay;
		logic [15:0] el;
		bx = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2 * lim) - lim);
		by = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2 * lim) - lim);
		ax = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 800) - 400);
		ay = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 800) - 400);
		el = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 101));
		send_tick($urandom_range(0, 7) != 0, bx, by, ax, ay, el);
	endtask

	initial begin
		int n, lim;
		sb.reset_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: defaults, elapsed-time fixes, bounds, extremes.
		send_tick(1, 0, 0, 0, 0, 10);
		send_tick(1, 100, -100, 20, -20, 0);
		send_tick(1, 100, -100, 20, -20, 101);
		send_tick(1, 100, -100, 20, -20, 100);
		send_tick(1, 100, -100, 20, -20, 65535);
		send_tick(1, 2880, -2880, 0, 0, 1);
		send_tick(1, 2881, 0, 0, 0, 10);
		send_tick(1, 0, -2881, 0, 0, 10);
		send_tick(0, 1000, 1000, 0, 0, 10);
		send_tick(1, 32767, -32768, 32767, -32768, 1);
		send_tick(1, 0, 0, -32768, 32767, 1);
		send_tick(1, -32768, 32767, 0, 0, 50);
		drain();

		// Extreme registers: huge gains saturate motors, zero weight freezes filter.
		write_reg(REG_GAIN_PROP, 24'hffffff);
		write_reg(REG_GAIN_INTEGRAL, 24'hffffff);
		write_reg(REG_GAIN_DERIV, 24'hffffff);
		write_reg(REG_EMA_WEIGHT, 24'hffffff);
		write_reg(REG_PLATE_LIMIT, 24'hffffff);
		write_reg(REG_BASE_ANGLE, 24'hffffff);
		write_reg(REG_NONE, 24'h123456);
		send_tick(1, 32767, -32768, -32768, 32767, 1);
		send_tick(1, -32768, 32767, 32767, -32768, 1);
		send_tick(1, 32767, 32767, -32768, -32768, 100);
		send_tick(1, 0, 0, 0, 0, 1);
		drain();
		write_reg(REG_GAIN_PROP, 0);
		write_reg(REG_GAIN_INTEGRAL, 0);
		write_reg(REG_GAIN_DERIV, 0);
		write_reg(REG_EMA_WEIGHT, 0);
		write_reg(REG_PLATE_LIMIT, 0);
		write_reg(REG_BASE_ANGLE, 0);
		send_tick(1, 0, 0, 5, -5, 10);
		send_tick(1, 1, 1, 5, -5, 10);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_GAIN_PROP, ph == 1 ? 24'hffffff : 24'($urandom_range(0, 40000)));
			write_reg(REG_GAIN_INTEGRAL, 24'($urandom_range(0, 40000)));
			write_reg(REG_GAIN_DERIV, ph == 2 ? 24'hffffff : 24'($urandom_range(0, 20000)));
			write_reg(REG_EMA_WEIGHT, ph == 3 ? 24'h00ffff : 24'($urandom_range(0, 65535)));
			lim = ph == 4 ? 32767 : $urandom_range(500, 4000);
			write_reg(REG_PLATE_LIMIT, 24'(lim));
			write_reg(REG_BASE_ANGLE, ph == 5 ? 24'd23040 : 24'($urandom_range(0, 23040)));
			n = 0;
			while (n < 215) begin
				int burst;
				burst = $urandom_range(1, 8);
				for (int k = 0; k < burst && n < 215; k++) begin
					random_tick(lim > 4000 ? 4000 : lim);
					n++;
				end
				if ($urandom_range(0, 1)) repeat ($urandom_range(1, 600)) @(negedge clk);
				if (n >= 100 && n - burst < 100) while (sb.pending.size() != 0) @(negedge clk);
			end
			drain();
		end

		stim_done = 1;
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("two_axis_pid_tilt_mixer_test: PASS");
		else
			$display("two_axis_pid_tilt_mixer_test: FAIL");
		$finish;
	end
endmodule
